// ===== src/bta_pkg.sv =====
`default_nettype none

package bta_pkg;

  // Register and code widths fixed by the block definition
  localparam int ACTIVE_W = 5;
  localparam int STATUS_W = 2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // Request operation codes
  localparam logic FUNC_TAKE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic excl;   // leave the selected cell out of the minimum search
    logic wr;     // write the selected cell's ticket
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/bta_cell.sv =====
`default_nettype none

// One requester slot: holds its ticket and folds it into the scan token
// that passes by, one cell per cycle.
module bta_cell #(
  parameter int INDEX       = 0,
  parameter int IDX_W       = 4,
  parameter int COUNT_W     = 5,
  parameter int TICKET_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  bta_pkg::cell_ctl_t      ctl,
  input  wire  [IDX_W-1:0]        sel_idx,
  input  wire  [TICKET_BITS-1:0]  wr_data,
  input  wire  [COUNT_W-1:0]      count,
  input  wire                     in_valid,
  input  wire  [TICKET_BITS-1:0]  in_max,
  input  wire                     in_found,
  input  wire  [TICKET_BITS-1:0]  in_best_tk,
  input  wire  [IDX_W-1:0]        in_best_idx,
  output logic                    out_valid,
  output logic [TICKET_BITS-1:0]  out_max,
  output logic                    out_found,
  output logic [TICKET_BITS-1:0]  out_best_tk,
  output logic [IDX_W-1:0]        out_best_idx
);

  logic [TICKET_BITS-1:0] ticket;
  logic                   active;
  logic                   selected;
  logic                   take_min;

  assign active   = count > COUNT_W'(INDEX);
  assign selected = sel_idx == IDX_W'(INDEX);
  // strict less-than keeps the lower index on a tie, since cells run upward
  assign take_min = active && !(ctl.excl && selected) && (ticket != '0) &&
                    (!in_found || (ticket < in_best_tk));

  always_ff @(posedge clk) begin
    if (rst) begin
      ticket    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.wr && selected) begin
        ticket <= wr_data;
      end
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_max      <= (active && (ticket > in_max)) ? ticket : in_max;
    out_found    <= in_found | take_min;
    out_best_tk  <= take_min ? ticket : in_best_tk;
    out_best_idx <= take_min ? IDX_W'(INDEX) : in_best_idx;
  end

endmodule

`default_nettype wire

// ===== src/bakery_ticket_arbiter.sv =====
`default_nettype none

// Channel   Dir  Handshake             Payload
// -------   ---  --------------------  ---------------------------------------------
// request   in   in_valid / in_stall   func, thread_id
// result    out  out_valid / out_stall ticket_given, grant_valid, grant_thread, status
// config    in   cfg_valid / cfg_ready cfg_data (active_threads)
//
// After a request is accepted, a scan token walks the row of ticket cells,
// one cell per cycle, gathering the largest active ticket and the lowest
// (ticket, index) pair, and the result is loaded from it. The next request
// can be taken in the cycle after the result is loaded. Synchronous reset
// clears every ticket and sets active_threads to 16. A result held by
// out_stall does not block the next request; the write-back of that request
// waits only for the result register.
module bakery_ticket_arbiter #(
  parameter int MAX_THREADS = 16,
  parameter int TICKET_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  // request channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                func,
  input  wire  [$clog2(MAX_THREADS)-1:0]     thread_id,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [TICKET_BITS-1:0]             ticket_given,
  output logic                               grant_valid,
  output logic [$clog2(MAX_THREADS)-1:0]     grant_thread,
  output logic [bta_pkg::STATUS_W-1:0]       status,
  // configuration channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [bta_pkg::ACTIVE_W-1:0]       cfg_data
);

  localparam int IDX_W   = $clog2(MAX_THREADS);
  localparam int COUNT_W = $clog2(MAX_THREADS + 1);
  localparam int CMP_W   = COUNT_W + 1;
  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration
  logic [bta_pkg::ACTIVE_W-1:0] active_threads;
  logic [COUNT_W-1:0]           eff_count;

  // Held request
  logic                   req_func;
  logic [IDX_W-1:0]       req_tid;
  logic                   req_in_range;
  logic                   launch;

  // Scan summary captured off the end of the row
  logic                   hold_sat;
  logic [TICKET_BITS-1:0] hold_given;
  logic                   hold_found;
  logic [TICKET_BITS-1:0] hold_best_tk;
  logic [IDX_W-1:0]       hold_best_idx;

  // Token positions: entry 0 is the launch point, entry i+1 leaves cell i
  logic                   sc_valid    [0:MAX_THREADS];
  logic [TICKET_BITS-1:0] sc_max      [0:MAX_THREADS];
  logic                   sc_found    [0:MAX_THREADS];
  logic [TICKET_BITS-1:0] sc_best_tk  [0:MAX_THREADS];
  logic [IDX_W-1:0]       sc_best_idx [0:MAX_THREADS];

  bta_pkg::cell_ctl_t     cell_ctl;
  logic [TICKET_BITS-1:0] wr_data;

  logic                   in_accept;
  logic                   in_range_now;
  logic                   out_free;
  logic                   commit;
  logic                   new_wins;
  logic [TICKET_BITS-1:0] end_max;
  logic [TICKET_BITS-1:0] given_next;
  logic                   sat_next;
  logic [TICKET_BITS-1:0] ticket_given_next;
  logic                   grant_valid_next;
  logic [IDX_W-1:0]       grant_thread_next;
  logic [bta_pkg::STATUS_W-1:0] status_next;

  // Config writes must arrive only while idle; the block does not enforce it, and the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_threads <= bta_pkg::ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_threads <= cfg_data;
    end
  end

  // Clamp the register to the number of cells actually built
  assign eff_count = (int'(active_threads) > MAX_THREADS) ? COUNT_W'(MAX_THREADS)
                                                          : COUNT_W'(active_threads);

  assign in_stall     = (state != ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign in_range_now = CMP_W'(thread_id) < CMP_W'(eff_count);

  // Launch an empty token into the first cell
  assign sc_valid[0]    = launch;
  assign sc_max[0]      = '0;
  assign sc_found[0]    = 1'b0;
  assign sc_best_tk[0]  = '0;
  assign sc_best_idx[0] = '0;

  // Only the requester's own slot changes, so leave it out of the minimum
  // search and fold its new value in at the end.
  assign out_free = !(out_valid && out_stall);
  assign commit   = (state == ST_FINISH) && out_free;
  assign cell_ctl = '{excl: req_in_range, wr: commit && req_in_range};
  assign wr_data  = (req_func == bta_pkg::FUNC_TAKE) ? hold_given : '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_THREADS; gi++) begin : g_cell
      bta_cell #(
        .INDEX       (gi),
        .IDX_W       (IDX_W),
        .COUNT_W     (COUNT_W),
        .TICKET_BITS (TICKET_BITS)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctl          (cell_ctl),
        .sel_idx      (req_tid),
        .wr_data      (wr_data),
        .count        (eff_count),
        .in_valid     (sc_valid[gi]),
        .in_max       (sc_max[gi]),
        .in_found     (sc_found[gi]),
        .in_best_tk   (sc_best_tk[gi]),
        .in_best_idx  (sc_best_idx[gi]),
        .out_valid    (sc_valid[gi+1]),
        .out_max      (sc_max[gi+1]),
        .out_found    (sc_found[gi+1]),
        .out_best_tk  (sc_best_tk[gi+1]),
        .out_best_idx (sc_best_idx[gi+1])
      );
    end
  endgenerate

  // Next ticket: largest plus one, pinned at the top of the range
  assign end_max    = sc_max[MAX_THREADS];
  assign sat_next   = (end_max == TICKET_MAX);
  assign given_next = sat_next ? TICKET_MAX : end_max + TICKET_BITS'(1);

  // New ticket against the best of the others, lower index on a tie
  assign new_wins = !hold_found || (hold_given < hold_best_tk) ||
                    ((hold_given == hold_best_tk) && (req_tid < hold_best_idx));

  always_comb begin
    ticket_given_next = '0;
    grant_valid_next  = hold_found;
    grant_thread_next = hold_best_idx;
    status_next       = bta_pkg::STATUS_OK;
    if (!req_in_range) begin
      status_next = bta_pkg::STATUS_RANGE;
    end else if (req_func == bta_pkg::FUNC_TAKE) begin
      ticket_given_next = hold_given;
      grant_valid_next  = 1'b1;
      grant_thread_next = new_wins ? req_tid : hold_best_idx;
      status_next       = hold_sat ? bta_pkg::STATUS_SAT : bta_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Fire a token in the cycle after a request is taken
      launch <= in_accept;
      // Load a new result, or drop the one just taken
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sc_valid[MAX_THREADS]) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: hold the request, capture the scan, load the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func     <= func;
      req_tid      <= thread_id;
      req_in_range <= in_range_now;
    end
    if ((state == ST_SCAN) && sc_valid[MAX_THREADS]) begin
      hold_sat      <= sat_next;
      hold_given    <= given_next;
      hold_found    <= sc_found[MAX_THREADS];
      hold_best_tk  <= sc_best_tk[MAX_THREADS];
      hold_best_idx <= sc_best_idx[MAX_THREADS];
    end
    if (commit) begin
      ticket_given <= ticket_given_next;
      grant_valid  <= grant_valid_next;
      grant_thread <= grant_thread_next;
      status       <= status_next;
    end
  end

  // A token reaches the end of the row only during a scan
  assert property (@(posedge clk) disable iff (rst)
    sc_valid[MAX_THREADS] |-> state == ST_SCAN)
    else $error("scan token left the row outside a scan");

  // A launch follows an accepted request and nothing else
  assert property (@(posedge clk) disable iff (rst)
    launch |-> $past(in_valid && !in_stall))
    else $error("scan launched without an accepted request");

  // No grant holder means index zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !grant_valid |-> grant_thread == '0)
    else $error("grant_thread nonzero with no grant");

  // A range error hands out no ticket
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bta_pkg::STATUS_RANGE |-> ticket_given == '0)
    else $error("ticket given on an out-of-range request");

  // A saturated ticket is still held, so someone holds the grant
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bta_pkg::STATUS_SAT |-> grant_valid &&
      ticket_given == TICKET_MAX)
    else $error("saturated request without grant or full ticket");

endmodule

`default_nettype wire

// ===== test/tb_bakery_ticket_arbiter.sv =====
`timescale 1ns / 1ps

module tb_bakery_ticket_arbiter;

  // Scan span of one request at the default size, walking the row one cell per cycle.
  localparam int SCAN_CYCLES = 16 + 2;
  // Cycles with no accepted request, result or register write before giving up.
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic       op;
    logic [3:0] tid;
  } ticket_req_t;

  typedef struct packed {
    logic [15:0] ticket;
    logic        grant_valid;
    logic [3:0]  holder;
    logic [1:0]  status;
  } grant_report_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        func      = bta_pkg::FUNC_TAKE;
  logic [3:0]  thread_id = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [4:0]  cfg_data  = '0;

  logic        in_stall;
  logic        out_valid;
  logic [15:0] ticket_given;
  logic        grant_valid;
  logic [3:0]  grant_thread;
  logic [1:0]  status;
  logic        cfg_ready;

  // Shadow copy of the ticket row and the active count.
  logic [15:0] held_ticket [16];
  logic [4:0]  active_cfg = bta_pkg::ACTIVE_RESET;

  ticket_req_t   ticket_reqs[$];
  grant_report_t grant_reports_due[$];

  logic no_idle    = 1'b0;
  int   errors     = 0;
  int   quiet_span = 0;

  bakery_ticket_arbiter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .thread_id    (thread_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ticket_given (ticket_given),
    .grant_valid  (grant_valid),
    .grant_thread (grant_thread),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one request to the shadow row and return the report the block
  // should give for it. Entries at or above the active count keep their
  // tickets but take no part in the maximum or the grant.
  function automatic grant_report_t predict_grant(logic op, logic [3:0] tid);
    grant_report_t r;
    int            n;
    logic [15:0]   top;
    logic [15:0]   best;
    r    = '0;
    top  = '0;
    best = '0;
    // A count above the row size acts as the full row.
    n = (active_cfg > 5'd16) ? 16 : int'(active_cfg);
    if (int'(tid) >= n) begin
      r.status = bta_pkg::STATUS_RANGE;
    end else if (op == bta_pkg::FUNC_TAKE) begin
      // The requester's own ticket counts toward the maximum.
      for (int i = 0; i < n; i++) begin
        if (held_ticket[i] > top) top = held_ticket[i];
      end
      if (top == 16'hFFFF) begin
        r.ticket = 16'hFFFF;
        r.status = bta_pkg::STATUS_SAT;
      end else begin
        r.ticket = top + 16'd1;
      end
      held_ticket[tid] = r.ticket;
    end else begin
      held_ticket[tid] = '0;
    end
    // Lowest nonzero ticket wins; strict compare leaves ties with the lower index.
    for (int i = 0; i < n; i++) begin
      if (held_ticket[i] != '0 && (!r.grant_valid || held_ticket[i] < best)) begin
        r.grant_valid = 1'b1;
        best          = held_ticket[i];
        r.holder      = i[3:0];
      end
    end
    return r;
  endfunction

  task automatic compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic queue_req(logic op, logic [3:0] tid);
    ticket_reqs.push_back('{op: op, tid: tid});
  endtask

  // Hold until every queued request is accepted and every report is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (ticket_reqs.size() != 0 || in_valid || grant_reports_due.size() != 0);
  endtask

  // Write active_threads; only called while the block is drained.
  task automatic write_active(logic [4:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    active_cfg = v;
    @(negedge clk);
  endtask

  // Request driver: hold the payload while stalled, otherwise present the
  // next queued request or idle for a cycle at random.
  always @(posedge clk) begin : request_driver
    ticket_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) grant_reports_due.push_back(predict_grant(func, thread_id));
      if (!in_valid || !in_stall) begin
        if (ticket_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
          nxt       = ticket_reqs.pop_front();
          in_valid  <= 1'b1;
          func      <= nxt.op;
          thread_id <= nxt.tid;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare every accepted report with the oldest one due,
  // and stall the result channel at random.
  always @(posedge clk) begin : result_monitor
    grant_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got ticket %0d grant %0b/%0d status %0d",
                   $time, ticket_given, grant_valid, grant_thread, status);
          errors++;
        end else begin
          want = grant_reports_due.pop_front();
          compare_field("ticket_given", want.ticket, ticket_given);
          compare_field("grant_valid", want.grant_valid, grant_valid);
          compare_field("grant_thread", want.holder, grant_thread);
          compare_field("status", want.status, status);
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < 17);
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin : progress_watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_span <= 0;
    end else if (quiet_span >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_span <= quiet_span + 1;
    end
  end

  initial begin : stimulus
    int          seg_cfg [9];
    int          n;
    logic        op;
    logic [3:0]  tid;
    for (int i = 0; i < 16; i++) held_ticket[i] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full row after reset, repeat request, release without a
    // ticket, releases down to an empty grant.
    queue_req(bta_pkg::FUNC_TAKE, 4'd0);
    queue_req(bta_pkg::FUNC_TAKE, 4'd15);
    queue_req(bta_pkg::FUNC_TAKE, 4'd15);
    queue_req(bta_pkg::FUNC_TAKE, 4'd7);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd3);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd15);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd0);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd7);
    queue_req(bta_pkg::FUNC_TAKE, 4'd10);
    wait_drained();

    // Lower the count: entry 10 keeps its ticket but drops out, so entry 0
    // draws the same ticket; out-of-range requests change nothing.
    write_active(5'd4);
    queue_req(bta_pkg::FUNC_TAKE, 4'd0);
    queue_req(bta_pkg::FUNC_TAKE, 4'd12);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd9);
    queue_req(bta_pkg::FUNC_TAKE, 4'd3);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd3);
    wait_drained();

    // Raise it again: entries 0 and 10 tie and the lower index wins.
    write_active(5'd16);
    queue_req(bta_pkg::FUNC_TAKE, 4'd5);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd0);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd10);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd5);
    wait_drained();

    // Count zero: every request is out of range.
    write_active(5'd0);
    queue_req(bta_pkg::FUNC_TAKE, 4'd0);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd0);
    wait_drained();

    // Count above the row size acts as the full row.
    write_active(5'd31);
    queue_req(bta_pkg::FUNC_TAKE, 4'd15);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd15);
    queue_req(bta_pkg::FUNC_TAKE, 4'd9);
    wait_drained();

    write_active(5'd1);
    queue_req(bta_pkg::FUNC_TAKE, 4'd0);
    queue_req(bta_pkg::FUNC_TAKE, 4'd1);
    queue_req(bta_pkg::FUNC_RELEASE, 4'd0);
    wait_drained();

    // Random: mostly in-range take/release mixes per count setting, with
    // some out-of-range indexes; one segment runs with no idling at all.
    seg_cfg = '{16, 1, 31, 0, 2, 0, 8, 0, 16};
    seg_cfg[5] = $urandom_range(0, 31);
    seg_cfg[7] = $urandom_range(0, 31);
    for (int s = 0; s < 9; s++) begin
      write_active(5'(seg_cfg[s]));
      n       = (seg_cfg[s] > 16) ? 16 : seg_cfg[s];
      no_idle = (s == 5);
      for (int k = 0; k < 56; k++) begin
        op  = ($urandom_range(0, 99) < 55) ? bta_pkg::FUNC_TAKE : bta_pkg::FUNC_RELEASE;
        tid = (n == 0 || $urandom_range(0, 99) < 15) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, n - 1));
        queue_req(op, tid);
      end
      wait_drained();
    end
    no_idle = 1'b0;

    // Let any stray result surface before the verdict.
    repeat (2 * SCAN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
